>>> sv/assert_macros.svh
// Assertion macros used by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while reset is released.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/sjf_pkg.sv
// Types and constants of the shortest-job-first scheduler.
`timescale 1ns / 1ps
package sjf_pkg;

	localparam int MAX_JOBS = 32;
	localparam int IDX_W    = $clog2(MAX_JOBS);
	localparam int CNT_W    = $clog2(MAX_JOBS + 1);
	localparam int ARR_W    = 16;
	localparam int BURST_W  = 16;
	localparam int TIME_W   = 22;
	localparam int ID_W     = 6;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE
	} state_t;

endpackage

>>> sv/sjf_nonpreemptive_scheduler.sv
// Non-preemptive shortest-job-first scheduler: job store, scan unit and sequencer.
// Loading: one job per cycle; busy stays low until the item with last_job set.
// Scheduling: each pick scans the stored jobs through one compare unit; a pick
// that finds no arrived job moves the clock to the earliest pending arrival and
// scans again. Results strobe once per job, in order.
// Reset clears the job count, done flags, clock and sequencer; the store is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sjf_nonpreemptive_scheduler (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [sjf_pkg::ARR_W-1:0]      arrival_time,
	input  logic [sjf_pkg::BURST_W-1:0]    burst_time,
	input  logic                           last_job,
	output logic                           result_valid,
	output logic [sjf_pkg::ID_W-1:0]       job_id,
	output logic [sjf_pkg::TIME_W-1:0]     wait_time,
	output logic [sjf_pkg::TIME_W-1:0]     turnaround,
	output logic                           last_result
);

	sjf_pkg::state_t state_q, state_d;

	logic [sjf_pkg::ARR_W-1:0]    arrival_mem [sjf_pkg::MAX_JOBS];
	logic [sjf_pkg::BURST_W-1:0]  burst_mem   [sjf_pkg::MAX_JOBS];

	logic [sjf_pkg::CNT_W-1:0]    count_q;
	logic [sjf_pkg::CNT_W-1:0]    emitted_q;
	logic [sjf_pkg::CNT_W-1:0]    issue_q;
	logic [sjf_pkg::MAX_JOBS-1:0] done_q;
	logic [sjf_pkg::TIME_W-1:0]   clock_q;

	logic                         cmp_vld_s1;
	logic                         done_s1;
	logic [sjf_pkg::IDX_W-1:0]    idx_s1;
	logic [sjf_pkg::ARR_W-1:0]    arr_s1;
	logic [sjf_pkg::BURST_W-1:0]  burst_s1;

	logic                         found_q;
	logic [sjf_pkg::IDX_W-1:0]    best_idx_q;
	logic [sjf_pkg::ARR_W-1:0]    best_arr_q;
	logic [sjf_pkg::BURST_W-1:0]  best_burst_q;
	logic [sjf_pkg::ARR_W-1:0]    min_arr_q;

	logic                         result_valid_q;
	logic [sjf_pkg::ID_W-1:0]     job_id_q;
	logic [sjf_pkg::TIME_W-1:0]   wait_q;
	logic [sjf_pkg::TIME_W-1:0]   tat_q;
	logic                         last_result_q;

	logic accept;
	logic mem_we;
	logic scan_init;
	logic issue_more;
	logic scan_end;
	logic pick_now;
	logic set_last;
	logic eligible;
	logic better;
	logic [sjf_pkg::TIME_W-1:0] wait_calc;
	logic [sjf_pkg::TIME_W-1:0] tat_calc;
	logic [sjf_pkg::CNT_W-1:0]  emitted_inc;

	assign accept      = start && (state_q == sjf_pkg::ST_IDLE);
	assign issue_more  = issue_q < count_q;
	assign scan_end    = !issue_more && !cmp_vld_s1;
	assign emitted_inc = emitted_q + sjf_pkg::CNT_W'(1);
	assign set_last    = emitted_inc == count_q;

	assign eligible = !done_s1 && ({{(sjf_pkg::TIME_W-sjf_pkg::ARR_W){1'b0}}, arr_s1} <= clock_q);
	assign better   = !found_q || (burst_s1 < best_burst_q) ||
	                  ((burst_s1 == best_burst_q) && (arr_s1 < best_arr_q));

	assign wait_calc = clock_q - {{(sjf_pkg::TIME_W-sjf_pkg::ARR_W){1'b0}}, best_arr_q};
	assign tat_calc  = wait_calc + {{(sjf_pkg::TIME_W-sjf_pkg::BURST_W){1'b0}}, best_burst_q};

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			sjf_pkg::ST_IDLE: begin
				if (start && last_job) state_d = sjf_pkg::ST_SCAN;
			end
			sjf_pkg::ST_SCAN: begin
				if (scan_end) state_d = sjf_pkg::ST_DECIDE;
			end
			sjf_pkg::ST_DECIDE: begin
				if (found_q && set_last) state_d = sjf_pkg::ST_IDLE;
				else                     state_d = sjf_pkg::ST_SCAN;
			end
			default: state_d = sjf_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		mem_we    = 1'b0;
		scan_init = 1'b0;
		pick_now  = 1'b0;
		case (state_q)
			sjf_pkg::ST_IDLE: begin
				mem_we    = accept && (count_q < sjf_pkg::CNT_W'(sjf_pkg::MAX_JOBS));
				scan_init = accept && last_job;
			end
			sjf_pkg::ST_SCAN: begin
				scan_init = 1'b0;
			end
			sjf_pkg::ST_DECIDE: begin
				pick_now  = found_q;
				scan_init = !(found_q && set_last);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sjf_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// Job store and its registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			arrival_mem[count_q[sjf_pkg::IDX_W-1:0]] <= arrival_time;
			burst_mem[count_q[sjf_pkg::IDX_W-1:0]]   <= burst_time;
		end
		arr_s1   <= arrival_mem[issue_q[sjf_pkg::IDX_W-1:0]];
		burst_s1 <= burst_mem[issue_q[sjf_pkg::IDX_W-1:0]];
		idx_s1   <= issue_q[sjf_pkg::IDX_W-1:0];
		done_s1  <= done_q[issue_q[sjf_pkg::IDX_W-1:0]];
	end

	// Scan control, best candidate and schedule state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			emitted_q    <= '0;
			issue_q      <= '0;
			done_q       <= '0;
			clock_q      <= '0;
			cmp_vld_s1   <= 1'b0;
			found_q      <= 1'b0;
			best_idx_q   <= '0;
			best_arr_q   <= '0;
			best_burst_q <= '0;
			min_arr_q    <= '1;
		end else begin
			if (mem_we) count_q <= count_q + sjf_pkg::CNT_W'(1);

			if (scan_init) begin
				issue_q    <= '0;
				cmp_vld_s1 <= 1'b0;
				found_q    <= 1'b0;
				min_arr_q  <= '1;
			end else if (state_q == sjf_pkg::ST_SCAN) begin
				cmp_vld_s1 <= issue_more;
				if (issue_more) issue_q <= issue_q + sjf_pkg::CNT_W'(1);
				if (cmp_vld_s1) begin
					if (eligible && better) begin
						found_q      <= 1'b1;
						best_idx_q   <= idx_s1;
						best_arr_q   <= arr_s1;
						best_burst_q <= burst_s1;
					end
					if (!done_s1 && (arr_s1 < min_arr_q)) min_arr_q <= arr_s1;
				end
			end

			if (state_q == sjf_pkg::ST_DECIDE) begin
				if (!found_q) begin
					// Nothing has arrived yet: jump to the earliest pending arrival.
					clock_q <= {{(sjf_pkg::TIME_W-sjf_pkg::ARR_W){1'b0}}, min_arr_q};
				end else if (set_last) begin
					count_q   <= '0;
					emitted_q <= '0;
					done_q    <= '0;
					clock_q   <= '0;
				end else begin
					clock_q   <= clock_q +
					             {{(sjf_pkg::TIME_W-sjf_pkg::BURST_W){1'b0}}, best_burst_q};
					emitted_q <= emitted_inc;
					done_q[best_idx_q] <= 1'b1;
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			last_result_q  <= 1'b0;
		end else begin
			result_valid_q <= pick_now;
			last_result_q  <= pick_now && set_last;
		end
	end

	always_ff @(posedge clk) begin
		if (pick_now) begin
			job_id_q <= sjf_pkg::ID_W'({1'b0, best_idx_q} + (sjf_pkg::IDX_W+1)'(1));
			wait_q   <= wait_calc;
			tat_q    <= tat_calc;
		end
	end

	assign busy         = state_q != sjf_pkg::ST_IDLE;
	assign result_valid = result_valid_q;
	assign job_id       = job_id_q;
	assign wait_time    = wait_q;
	assign turnaround   = tat_q;
	assign last_result  = last_result_q;

	`ASSERT_CLK(a_last_ends_run, last_result |-> (state_q == sjf_pkg::ST_IDLE), "last result while still scheduling")
	`ASSERT_CLK(a_mid_result_scans, (result_valid && !last_result) |-> (state_q == sjf_pkg::ST_SCAN), "result without rescan")
	`ASSERT_CLK(a_emitted_bound, (state_q == sjf_pkg::ST_SCAN) |-> (emitted_q < count_q), "emitted count overran job count")
	`ASSERT_CLK(a_last_starts, (accept && last_job) |=> busy, "last job did not start schedule")
	`ASSERT_CLK(a_last_has_strobe, !last_result || result_valid, "last mark without strobe")
	`ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !result_valid, "result strobe after reset")

endmodule

>>> bench/sjf_schedule_checker.sv
// Checker that predicts the scheduler's job order and compares every result item.
`timescale 1ns / 1ps

module sjf_schedule_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic [sjf_pkg::ARR_W-1:0]    arrival_time,
	input  logic [sjf_pkg::BURST_W-1:0]  burst_time,
	input  logic                         last_job,
	input  logic                         result_valid,
	input  logic [sjf_pkg::ID_W-1:0]     job_id,
	input  logic [sjf_pkg::TIME_W-1:0]   wait_time,
	input  logic [sjf_pkg::TIME_W-1:0]   turnaround,
	input  logic                         last_result,
	output int unsigned                  fail_count,
	output int unsigned                  pending_results
);

	typedef struct {
		logic [sjf_pkg::ID_W-1:0]   id;
		logic [sjf_pkg::TIME_W-1:0] waited;
		logic [sjf_pkg::TIME_W-1:0] tat;
		logic                       final_job;
	} sched_rec_t;

	logic [sjf_pkg::ARR_W-1:0]   arrivals [sjf_pkg::MAX_JOBS];
	logic [sjf_pkg::BURST_W-1:0] bursts [sjf_pkg::MAX_JOBS];
	int unsigned                 jobs_loaded = 0;
	int unsigned                 mismatches = 0;
	sched_rec_t                  expected_jobs [$];

	// Runs the whole set to completion and queues one record per job in run order.
	task automatic schedule_loaded_jobs();
		logic [sjf_pkg::MAX_JOBS-1:0] finished;
		logic [sjf_pkg::TIME_W-1:0]   now;
		logic [sjf_pkg::TIME_W-1:0]   next_arrival;
		int                           pick;
		int unsigned                  emitted;
		sched_rec_t                   rec;
		finished = '0;
		now = '0;
		emitted = 0;
		while (emitted < jobs_loaded) begin
			pick = -1;
			for (int k = 0; k < jobs_loaded; k++) begin
				if (finished[k] || sjf_pkg::TIME_W'(arrivals[k]) > now)
					continue;
				if (pick < 0 || bursts[k] < bursts[pick] ||
				    (bursts[k] == bursts[pick] && arrivals[k] < arrivals[pick]))
					pick = k;
			end
			// Nothing has arrived yet, so the clock skips ahead to the next arrival.
			if (pick < 0) begin
				next_arrival = '1;
				for (int k = 0; k < jobs_loaded; k++)
					if (!finished[k] && sjf_pkg::TIME_W'(arrivals[k]) < next_arrival)
						next_arrival = sjf_pkg::TIME_W'(arrivals[k]);
				now = next_arrival;
				continue;
			end
			rec.id = sjf_pkg::ID_W'(pick + 1);
			rec.waited = now - sjf_pkg::TIME_W'(arrivals[pick]);
			rec.tat = rec.waited + sjf_pkg::TIME_W'(bursts[pick]);
			rec.final_job = (emitted + 1 == jobs_loaded);
			now = now + sjf_pkg::TIME_W'(bursts[pick]);
			finished[pick] = 1'b1;
			expected_jobs.push_back(rec);
			emitted++;
		end
		jobs_loaded = 0;
	endtask

	task automatic compare_result();
		sched_rec_t rec;
		if (expected_jobs.size() == 0) begin
			$error("result item with no job pending: job_id %0d", job_id);
			mismatches++;
			return;
		end
		rec = expected_jobs.pop_front();
		if (job_id !== rec.id) begin
			$error("job_id: expected %0d, got %0d", rec.id, job_id);
			mismatches++;
		end
		if (wait_time !== rec.waited) begin
			$error("wait_time: expected %0d, got %0d", rec.waited, wait_time);
			mismatches++;
		end
		if (turnaround !== rec.tat) begin
			$error("turnaround: expected %0d, got %0d", rec.tat, turnaround);
			mismatches++;
		end
		if (last_result !== rec.final_job) begin
			$error("last_result: expected %0d, got %0d", rec.final_job, last_result);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jobs_loaded = 0;
			expected_jobs.delete();
			fail_count <= 0;
			pending_results <= 0;
		end else begin
			if (result_valid)
				compare_result();
			if (start && !busy) begin
				// A full store drops the job, but its last mark still runs the set.
				if (jobs_loaded < sjf_pkg::MAX_JOBS) begin
					arrivals[jobs_loaded] = arrival_time;
					bursts[jobs_loaded] = burst_time;
					jobs_loaded++;
				end
				if (last_job)
					schedule_loaded_jobs();
			end
			fail_count <= mismatches;
			pending_results <= expected_jobs.size();
		end
	end

endmodule

>>> bench/tb_sjf_nonpreemptive_scheduler.sv
// Testbench top for the shortest-job-first scheduler: clock, reset, job stimulus and verdict.
`timescale 1ns / 1ps

module tb_sjf_nonpreemptive_scheduler;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         start = 1'b0;
	logic [sjf_pkg::ARR_W-1:0]    arrival_time = '0;
	logic [sjf_pkg::BURST_W-1:0]  burst_time = '0;
	logic                         last_job = 1'b0;
	logic                         busy;
	logic                         result_valid;
	logic [sjf_pkg::ID_W-1:0]     job_id;
	logic [sjf_pkg::TIME_W-1:0]   wait_time;
	logic [sjf_pkg::TIME_W-1:0]   turnaround;
	logic                         last_result;
	int unsigned                  fail_count;
	int unsigned                  pending_results;
	int unsigned                  items_sent = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	sjf_nonpreemptive_scheduler i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.arrival_time (arrival_time),
		.burst_time   (burst_time),
		.last_job     (last_job),
		.result_valid (result_valid),
		.job_id       (job_id),
		.wait_time    (wait_time),
		.turnaround   (turnaround),
		.last_result  (last_result)
	);

	sjf_schedule_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.arrival_time    (arrival_time),
		.burst_time      (burst_time),
		.last_job        (last_job),
		.result_valid    (result_valid),
		.job_id          (job_id),
		.wait_time       (wait_time),
		.turnaround      (turnaround),
		.last_result     (last_result),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	// Holds the job on the inputs until the edge at which the block takes it.
	task automatic offer_job(input logic [sjf_pkg::ARR_W-1:0] arr,
	                         input logic [sjf_pkg::BURST_W-1:0] bst, input logic last);
		start <= 1'b1;
		arrival_time <= arr;
		burst_time <= bst;
		last_job <= last;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	task automatic pause_sender(input int unsigned cycles);
		if (cycles == 0)
			return;
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_for_drain();
		start <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
	endtask

	function automatic int unsigned sender_gap();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(3, 1);
		return $urandom_range(60, 10);
	endfunction

	// Narrow ranges give many ties and crowded queues; the full range sets every bit.
	function automatic logic [15:0] pick_value(input int unsigned mode);
		case (mode)
			0: return 16'($urandom_range(7));
			1: return 16'($urandom_range(255));
			2: return 16'($urandom);
			default: return 16'($urandom_range(65535, 65520));
		endcase
	endfunction

	initial begin
		int unsigned set_index;
		int unsigned set_size;
		int unsigned roll;
		int unsigned arr_mode;
		int unsigned bst_mode;
		bit          steady;
		set_index = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single jobs: zero burst, and the largest arrival and burst.
		offer_job(16'd0, 16'd0, 1'b1);
		offer_job(16'hFFFF, 16'hFFFF, 1'b1);
		// Equal bursts settle on the earlier arrival, then on the lower position.
		offer_job(16'd0, 16'd10, 1'b0);
		offer_job(16'd0, 16'd10, 1'b0);
		offer_job(16'd0, 16'd5, 1'b0);
		offer_job(16'd2, 16'd5, 1'b0);
		offer_job(16'd1, 16'd5, 1'b1);
		wait_for_drain();
		// No job at time zero, with identical jobs after the jump.
		offer_job(16'd100, 16'd3, 1'b0);
		offer_job(16'd50, 16'd7, 1'b0);
		offer_job(16'd50, 16'd7, 1'b1);
		// A short late job never cuts in, and the clock jumps in mid-schedule.
		offer_job(16'd0, 16'd20, 1'b0);
		offer_job(16'd1, 16'd1, 1'b0);
		offer_job(16'd3, 16'd2, 1'b0);
		offer_job(16'd30000, 16'd0, 1'b0);
		offer_job(16'hFFFF, 16'd1, 1'b1);
		wait_for_drain();

		while (items_sent < 360) begin
			roll = $urandom_range(99);
			if (set_index == 0)
				set_size = sjf_pkg::MAX_JOBS + 2;
			else if (set_index == 1)
				set_size = sjf_pkg::MAX_JOBS;
			else if (roll < 65)
				set_size = $urandom_range(6, 1);
			else if (roll < 88)
				set_size = $urandom_range(20, 7);
			else if (roll < 96)
				set_size = sjf_pkg::MAX_JOBS;
			else
				set_size = $urandom_range(sjf_pkg::MAX_JOBS + 3, sjf_pkg::MAX_JOBS + 1);
			arr_mode = $urandom_range(3);
			bst_mode = $urandom_range(3);
			steady = ($urandom_range(3) == 0);
			for (int n = 1; n <= set_size; n++) begin
				offer_job(pick_value(arr_mode), pick_value(bst_mode), n == set_size);
				if (!steady)
					pause_sender(sender_gap());
			end
			if ($urandom_range(7) == 0)
				wait_for_drain();
			set_index++;
		end

		wait_for_drain();
		repeat (2 * sjf_pkg::MAX_JOBS + 10) @(posedge clk);
		if (fail_count == 0 && pending_results == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
